/* design/mfpa_pkg.sv */
// types and constants shared by the multi-frame pixel averager
`timescale 1ns / 1ps

package mfpa_pkg;

    localparam int IDX_W      = 11;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 22;
    localparam int DIV_W      = 7;
    localparam int CHANNELS   = 4;
    localparam int BYTE_W     = 8;
    localparam int MAX_FRAMES = 64;
    localparam int TDATA_W    = 80;
    localparam int PAD_W      = TDATA_W - IDX_W - CHANNELS * SAMPLE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [SUM_W-1:0] SUM_MAX         = '1;
    localparam logic [DIV_W-1:0] DIV_MAX         = DIV_W'(MAX_FRAMES);
    localparam logic [DIV_W-1:0] DIV_MIN         = DIV_W'(1);
    localparam logic [DIV_W-1:0] FRAME_COUNT_RST = DIV_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT   = 1'b0,
        REG_WIDE_CHANNELS = 1'b1
    } cfg_reg_t;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] samples_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]    sums_t;

    typedef struct packed {
        logic [DIV_W-1:0] frame_count;
        logic             wide_channels;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic             wide_channels;
        logic [DIV_W-1:0] divisor;
        sums_t            sums;
    } div_item_t;

endpackage

/* design/mfpa_line_store.sv */
// line store with read-modify-write of the four channel sums per position
`timescale 1ns / 1ps

module mfpa_line_store
    import mfpa_pkg::*;
#(
    parameter int LINE_WIDTH = 2048
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] in_index,
    input  logic             in_first,
    input  logic             in_last,
    input  samples_t         in_samples,
    input  cfg_t             cfg,
    output logic             div_valid,
    input  logic             div_ready,
    output div_item_t        div_item
);

    localparam int ADDR_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  pixel_index;
        logic              first;
        logic              last;
        logic              wide_channels;
        samples_t          samples;
    } rmw_t;

    sums_t mem [LINE_WIDTH];

    rmw_t  stage_reg;
    rmw_t  stage_next;
    logic  valid_reg;
    sums_t rdata_reg;
    logic  fwd_hit_reg;
    logic  fwd_hit_next;
    sums_t fwd_data_reg;

    logic              accept;
    logic              in_range;
    logic              advance;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    sums_t             old_sums;
    sums_t             new_sums;
    logic [DIV_W-1:0]  divisor;

    always_comb
    begin
        logic [SUM_W:0] sum_ext;
        sum_ext  = '0;
        advance  = !valid_reg || !stage_reg.last || div_ready;
        in_ready = advance;
        accept   = in_valid && advance;
        in_range = 32'(in_index) < LINE_WIDTH;
        rd_addr  = ADDR_W'(in_index);
        wr_en    = valid_reg && advance;

        stage_next.addr          = rd_addr;
        stage_next.pixel_index   = in_index;
        stage_next.first         = in_first;
        stage_next.last          = in_last;
        stage_next.wide_channels = cfg.wide_channels;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (cfg.wide_channels)
                stage_next.samples[c] = in_samples[c];
            else
                stage_next.samples[c] = {{(SAMPLE_W-BYTE_W){1'b0}}, in_samples[c][BYTE_W-1:0]};
        end

        old_sums = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_ext = {1'b0, old_sums[c]} + (SUM_W+1)'(stage_reg.samples[c]);
            if (stage_reg.first)
                new_sums[c] = SUM_W'(stage_reg.samples[c]);
            else if (sum_ext[SUM_W])
                new_sums[c] = SUM_MAX;
            else
                new_sums[c] = sum_ext[SUM_W-1:0];
        end

        fwd_hit_next = wr_en && (in_index == stage_reg.pixel_index);

        if (cfg.frame_count == '0)
            divisor = DIV_MIN;
        else if (cfg.frame_count > DIV_MAX)
            divisor = DIV_MAX;
        else
            divisor = cfg.frame_count;

        div_valid                  = valid_reg && stage_reg.last;
        div_item.pixel_index       = stage_reg.pixel_index;
        div_item.wide_channels     = stage_reg.wide_channels;
        div_item.divisor           = divisor;
        div_item.sums              = new_sums;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                valid_reg <= accept && in_range;
            if (accept)
                fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg    <= stage_next;
            fwd_data_reg <= new_sums;
            rdata_reg    <= mem[rd_addr];
        end
        if (wr_en)
            mem[stage_reg.addr] <= new_sums;
    end

endmodule

/* design/mfpa_divider.sv */
// pipelined restoring divider, one quotient bit per stage on four lanes
`timescale 1ns / 1ps

module mfpa_divider
    import mfpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] out_index,
    output samples_t         out_samples
);

    localparam int STEPS = SUM_W;

    typedef struct packed {
        logic [IDX_W-1:0]                  pixel_index;
        logic                              wide_channels;
        logic [DIV_W-1:0]                  divisor;
        logic [CHANNELS-1:0][DIV_W-1:0]    rem;
        sums_t                             dq;
    } lane_t;

    lane_t            stage_reg  [STEPS];
    lane_t            stage_next [STEPS];
    lane_t            src        [STEPS];
    logic [STEPS-1:0] valid_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    samples_t         out_samples_reg;
    samples_t         out_samples_next;
    logic             enable;

    always_comb
    begin
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           ge;
        logic [SUM_W-1:0] q;
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        q     = '0;

        enable   = !out_valid_reg || out_ready;
        in_ready = enable;

        src[0].pixel_index   = in_item.pixel_index;
        src[0].wide_channels = in_item.wide_channels;
        src[0].divisor       = in_item.divisor;
        src[0].rem           = '0;
        src[0].dq            = in_item.sums;
        for (int k = 1; k < STEPS; k++)
            src[k] = stage_reg[k-1];

        for (int k = 0; k < STEPS; k++)
        begin
            stage_next[k] = src[k];
            for (int c = 0; c < CHANNELS; c++)
            begin
                trial = {src[k].rem[c], src[k].dq[c][SUM_W-1]};
                diff  = trial - {1'b0, src[k].divisor};
                ge    = trial >= {1'b0, src[k].divisor};
                stage_next[k].rem[c] = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                stage_next[k].dq[c]  = {src[k].dq[c][SUM_W-2:0], ge};
            end
        end

        for (int c = 0; c < CHANNELS; c++)
        begin
            q = stage_reg[STEPS-1].dq[c];
            if (stage_reg[STEPS-1].wide_channels)
                out_samples_next[c] = (|q[SUM_W-1:SAMPLE_W]) ? '1 : q[SAMPLE_W-1:0];
            else if (|q[SUM_W-1:BYTE_W])
                out_samples_next[c] = {{(SAMPLE_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}};
            else
                out_samples_next[c] = {{(SAMPLE_W-BYTE_W){1'b0}}, q[BYTE_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg     <= {valid_reg[STEPS-2:0], in_valid};
            out_valid_reg <= valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            for (int k = 0; k < STEPS; k++)
                stage_reg[k] <= stage_next[k];
            out_index_reg   <= stage_reg[STEPS-1].pixel_index;
            out_samples_reg <= out_samples_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_samples = out_samples_reg;

endmodule

/* design/multi_frame_pixel_averager.sv */
// top level of the multi-frame pixel averager
//
//  channel   dir  word contents (lowest bit up)
//  s_axis    in   tdata: pixel_index, red_in, green_in, blue_in, alpha_in;
//                 tuser: first_frame; tlast: last_frame
//  m_axis    out  tdata: pixel_index_out, red_out, green_out, blue_out, alpha_out
//  cfg       in   cfg_index 0 frame_count, 1 wide_channels; cfg_data value
//
// one pixel per clock unless a stalled divider holds back a last-frame pixel; the average leaves via
// the line store read register, 22 divider stages and one output register
// same-position pixels on consecutive clocks are forwarded around the store
// a stalled output holds the divider; pixels that emit nothing keep flowing
// reset clears control only; the line store holds no state until written
`timescale 1ns / 1ps

module multi_frame_pixel_averager
    import mfpa_pkg::*;
#(
    parameter int LINE_WIDTH = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // pixel_index, red, green, blue, alpha
    input  logic                  s_axis_tuser,   // first_frame
    input  logic                  s_axis_tlast,   // last_frame
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // pixel_index_out, red, green, blue, alpha
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIV_W-1:0] frame_count_reg;
    logic             wide_channels_reg;
    cfg_t             cfg;

    logic             div_valid;
    logic             div_ready;
    div_item_t        div_item;
    logic [IDX_W-1:0] out_index;
    samples_t         out_samples;

    assign cfg_ready = 1'b1;
    assign cfg.frame_count   = frame_count_reg;
    assign cfg.wide_channels = wide_channels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= FRAME_COUNT_RST;
            wide_channels_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_data[DIV_W-1:0];
                REG_WIDE_CHANNELS: wide_channels_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    mfpa_line_store #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_index   (s_axis_tdata[IDX_W-1:0]),
        .in_first   (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .in_samples (s_axis_tdata[IDX_W +: CHANNELS*SAMPLE_W]),
        .cfg        (cfg),
        .div_valid  (div_valid),
        .div_ready  (div_ready),
        .div_item   (div_item)
    );

    mfpa_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (div_valid),
        .in_ready    (div_ready),
        .in_item     (div_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_index   (out_index),
        .out_samples (out_samples)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_samples, out_index};

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the multi-frame pixel averager
`timescale 1ns / 1ps

module tb_top;
    import mfpa_pkg::*;

    localparam int LINE_LEN      = 2048;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int PHASES        = 8;

    typedef enum logic {
        ROW_PIXEL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             first;
        logic             last;
        samples_t         chans;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        samples_t         chans;
    } avg_pixel_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              cfg_sel;
        logic [CFG_DATA_W-1:0] cfg_val;
        pixel_t                px;
        logic                  typed;
        samples_t              want;
    } stim_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // tb copy of the line store and registers
    logic [SUM_W-1:0]  line_sums [CHANNELS][LINE_LEN];
    bit                line_written [LINE_LEN];
    logic [IDX_W-1:0]  written_list [$];
    logic [DIV_W-1:0]  fc_setting   = FRAME_COUNT_RST;
    logic              wide_setting = 1'b1;

    avg_pixel_t pending_averages [$];
    stim_row_t  directed_rows [$];
    string      chan_names [CHANNELS] = '{"red", "green", "blue", "alpha"};

    int idle_mode        = 0;
    int mismatches       = 0;
    int pixels_sent      = 0;
    int averages_checked = 0;
    int cfg_writes       = 0;
    int cycle_count      = 0;

    multi_frame_pixel_averager #(
        .LINE_WIDTH(LINE_LEN)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            1: return $urandom_range(0, 99) < 74;
            3: return $urandom_range(0, 99) < 11;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            2: return $urandom_range(0, 99) < 74;
            3: return $urandom_range(0, 99) < 11;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int effective_divisor();
        if (fc_setting == '0)
            return 1;
        if (fc_setting > DIV_MAX)
            return MAX_FRAMES;
        return int'(fc_setting);
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return IDX_W'(LINE_LEN - 1);
            default: return IDX_W'($urandom_range(0, LINE_LEN - 1));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int line_positions(input int frames);
        int cap;
        cap = 96 / frames;
        if (cap < 1)
            cap = 1;
        if (cap > 4)
            cap = 4;
        return $urandom_range(1, cap);
    endfunction

    // accumulate one pixel into the line store; returns 1 when it emits an average
    function automatic bit average_pixel(input pixel_t px, output avg_pixel_t avg);
        logic [SAMPLE_W-1:0] mask;
        logic [SUM_W:0]      total;
        logic [SUM_W-1:0]    quotient;
        int                  div;
        mask = wide_setting ? 16'hFFFF : 16'h00FF;
        div = effective_divisor();
        avg.index = px.index;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (px.first)
                line_sums[c][px.index] = SUM_W'(px.chans[c] & mask);
            else
            begin
                total = {1'b0, line_sums[c][px.index]} + (SUM_W + 1)'(px.chans[c] & mask);
                line_sums[c][px.index] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
            end
            quotient = SUM_W'(line_sums[c][px.index] / div);
            avg.chans[c] = (quotient > mask) ? mask : quotient[SAMPLE_W-1:0];
        end
        if (px.first && !line_written[px.index])
        begin
            line_written[px.index] = 1'b1;
            written_list.push_back(px.index);
        end
        return px.last;
    endfunction

    function automatic void add_pixel_row(input logic [IDX_W-1:0] index, input logic first,
                                          input logic last, input samples_t chans,
                                          input logic typed, input samples_t want);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.px.index = index;
        row.px.first = first;
        row.px.last = last;
        row.px.chans = chans;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg_sel = sel;
        row.cfg_val = value;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input pixel_t px, input logic typed, input samples_t want);
        avg_pixel_t avg;
        while (sender_idles())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, px.chans, px.index};
        s_axis_tuser  <= px.first;
        s_axis_tlast  <= px.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
        if (average_pixel(px, avg))
        begin
            if (typed)
                avg.chans = want;
            pending_averages.push_back(avg);
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (sel == REG_FRAME_COUNT)
            fc_setting = value;
        else
            wide_setting = value[0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // frame-major line: every position gets frames pixels, first and last marked
    task automatic emit_line(input int frames, input int spots, input bit maxed);
        logic [IDX_W-1:0] where [4];
        int               order [4];
        int               j;
        int               tmp;
        bit               dup;
        pixel_t           px;
        for (int i = 0; i < spots; i++)
        begin
            do
            begin
                where[i] = rand_index();
                dup = 1'b0;
                for (int k = 0; k < i; k++)
                    if (where[k] == where[i])
                        dup = 1'b1;
            end
            while (dup);
            order[i] = i;
        end
        for (int f = 0; f < frames; f++)
        begin
            for (int i = spots - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int k = 0; k < spots; k++)
            begin
                px.index = where[order[k]];
                px.first = (f == 0);
                px.last = (f == frames - 1);
                for (int c = 0; c < CHANNELS; c++)
                    px.chans[c] = maxed ? 16'hFFFF : rand_sample();
                send_pixel(px, 1'b0, '0);
            end
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= !receiver_stalls();

    always @(posedge clk)
    begin
        avg_pixel_t got;
        avg_pixel_t exp_avg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.index = m_axis_tdata[IDX_W-1:0];
            got.chans = m_axis_tdata[IDX_W +: CHANNELS * SAMPLE_W];
            if (pending_averages.size() == 0)
                flag_mismatch($sformatf("average at index %0d with none expected", got.index));
            else
            begin
                exp_avg = pending_averages.pop_front();
                averages_checked++;
                if (got.index !== exp_avg.index)
                    flag_mismatch($sformatf("index: got %0d expected %0d",
                                            got.index, exp_avg.index));
                for (int c = 0; c < CHANNELS; c++)
                    if (got.chans[c] !== exp_avg.chans[c])
                        flag_mismatch($sformatf("%s at index %0d: got %h expected %h",
                                                chan_names[c], exp_avg.index,
                                                got.chans[c], exp_avg.chans[c]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_frame_pixel_averager regression: fail");
            $finish;
        end
    end

    initial
    begin
        int                    phase_fc [PHASES]   = '{1, 64, 2, 0, 127, 64, 3, 0};
        bit                    phase_wide [PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0};
        logic [CFG_DATA_W-1:0] value;
        int                    phase_start;
        int                    roll;
        int                    div;
        int                    frames;
        pixel_t                px;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: two frames, wide channels
        add_pixel_row(0, 1, 0, {4{16'hFFFF}}, 0, '0);
        add_pixel_row(0, 0, 1, {4{16'hFFFF}}, 1, {4{16'hFFFF}});
        add_pixel_row(IDX_W'(LINE_LEN - 1), 1, 1, '0, 1, '0);
        add_pixel_row(5, 1, 1, {16'd400, 16'd300, 16'd200, 16'd100},
                      1, {16'd200, 16'd150, 16'd100, 16'd50});
        // one frame too many saturates the quotient
        add_pixel_row(7, 1, 0, {4{16'hFFFF}}, 0, '0);
        add_pixel_row(7, 0, 0, {4{16'hFFFF}}, 0, '0);
        add_pixel_row(7, 0, 1, {4{16'hFFFF}}, 1, {4{16'hFFFF}});
        add_pixel_row(11'h555, 1, 0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 0, '0);
        add_pixel_row(11'h555, 0, 1, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 0, '0);
        add_pixel_row(11'h2AA, 1, 1, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 0, '0);
        // narrow channels use the low byte only
        add_cfg_row(REG_WIDE_CHANNELS, 7'd0);
        add_pixel_row(9, 1, 0, {4{16'h12FF}}, 0, '0);
        add_pixel_row(9, 0, 1, {4{16'hAB01}}, 1, {4{16'h0080}});
        add_pixel_row(10, 1, 0, {4{16'h00FF}}, 0, '0);
        add_pixel_row(10, 0, 0, {4{16'hFFFF}}, 0, '0);
        add_pixel_row(10, 0, 1, {4{16'hFFFF}}, 1, {4{16'h00FF}});
        // divisor zero acts as one, above the maximum acts as the maximum
        add_cfg_row(REG_FRAME_COUNT, 7'd0);
        add_pixel_row(11, 1, 1, {4{16'h1237}}, 1, {4{16'h0037}});
        add_cfg_row(REG_FRAME_COUNT, 7'd127);
        add_pixel_row(12, 1, 1, {4{16'h00C8}}, 1, {4{16'd3}});
        // width switched in the middle of a line
        add_cfg_row(REG_WIDE_CHANNELS, 7'd1);
        add_pixel_row(13, 1, 0, {4{16'h1234}}, 0, '0);
        add_cfg_row(REG_WIDE_CHANNELS, 7'd0);
        add_cfg_row(REG_FRAME_COUNT, 7'd1);
        add_pixel_row(13, 0, 1, {4{16'h1234}}, 1, {4{16'h00FF}});
        add_cfg_row(REG_WIDE_CHANNELS, 7'd1);
        add_pixel_row(14, 1, 1, {16'h7FFF, 16'h8000, 16'h0001, 16'hBEEF},
                      1, {16'h7FFF, 16'h8000, 16'h0001, 16'hBEEF});
        add_pixel_row(0, 1, 1, {4{16'h0002}}, 1, {4{16'h0002}});

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
                write_register(directed_rows[r].cfg_sel, directed_rows[r].cfg_val);
            else
                send_pixel(directed_rows[r].px, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                value = CFG_DATA_W'($urandom_range(1, MAX_FRAMES));
            else
                value = CFG_DATA_W'(phase_fc[ph]);
            write_register(REG_FRAME_COUNT, value);
            value = CFG_DATA_W'($urandom);
            value[0] = (ph == PHASES - 1) ? 1'($urandom_range(0, 1)) : phase_wide[ph];
            write_register(REG_WIDE_CHANNELS, value);
            idle_mode = ph % 4;
            phase_start = pixels_sent;
            // enough full-scale frames to saturate the sums
            if (wide_setting && effective_divisor() == MAX_FRAMES)
                emit_line(MAX_FRAMES + 2, 1, 1'b1);
            while (pixels_sent - phase_start < RANDOM_ITEMS / PHASES)
            begin
                roll = $urandom_range(0, 99);
                div = effective_divisor();
                if (roll < 70)
                    emit_line(div, line_positions(div), 1'b0);
                else if (roll < 85)
                begin
                    if (div == 1 || $urandom_range(0, 1) == 1)
                        frames = div + $urandom_range(1, 3);
                    else
                        frames = $urandom_range(1, div - 1);
                    emit_line(frames, line_positions(frames), 1'b0);
                end
                else
                begin
                    px.index = rand_index();
                    px.first = 1'($urandom_range(0, 1));
                    if (!px.first && !line_written[px.index])
                    begin
                        if (written_list.size() != 0)
                            px.index = written_list[$urandom_range(0, written_list.size() - 1)];
                        else
                            px.first = 1'b1;
                    end
                    px.last = ($urandom_range(0, 3) == 0);
                    for (int c = 0; c < CHANNELS; c++)
                        px.chans[c] = rand_sample();
                    send_pixel(px, 1'b0, '0);
                end
            end
        end

        wait_for_drain();
        $display("checked %0d averages from %0d pixels over %0d register writes",
                 averages_checked, pixels_sent, cfg_writes);
        $display("frame counts 0 to 127, both channel widths, sum and quotient saturation");
        if (mismatches == 0)
            $display("multi_frame_pixel_averager regression: pass");
        else
            $display("multi_frame_pixel_averager regression: fail");
        $finish;
    end

endmodule
